>>> sv/bfe_pkg.sv
package bfe_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W  = 8;
  localparam int DIM_W  = 11;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SUM_W  = PIX_W + 4;
  localparam int MUL_W  = 11;
  localparam int PROD_W = SUM_W + MUL_W;

  localparam logic [MUL_W-1:0] THIRD_MUL   = MUL_W'(683);
  localparam int               THIRD_SHIFT = 11;
  localparam logic [MUL_W-1:0] NINTH_MUL   = MUL_W'(1821);
  localparam int               NINTH_SHIFT = 14;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 1'b0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [PIX_W-1:0] pixel_in;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             frame_end;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    DIV_ONE,
    DIV_THIRD,
    DIV_NINTH
  } div_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] dim,
                                                  input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    res = dim;
    if (dim == '0) begin
      res = DIM_W'(1);
    end else if (dim > hi) begin
      res = hi;
    end
    return res;
  endfunction

  function automatic logic [MUL_W-1:0] div_mult(input div_t kind);
    logic [MUL_W-1:0] res;
    unique case (kind)
      DIV_THIRD: res = THIRD_MUL;
      DIV_NINTH: res = NINTH_MUL;
      default:   res = MUL_W'(1);
    endcase
    return res;
  endfunction

endpackage

>>> sv/bfe_ram.sv
module bfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/box_filter_3x3_edge_aware.sv
// 3x3 box filter over a raster pixel stream that averages only the neighbors
// inside the image and rounds down. Each result leaves once the pixel one row
// and one column later has arrived; after the last pixel of a frame, one flush
// beat per pending result drains the rest, and row_end and frame_end mark the
// results. Beats run one at a time through the line-store port: a beat that
// produces no result keeps the block busy for a line-store read, then a
// write-back; a beat that produces a result runs through read, write-back,
// window sum, reciprocal multiply and output load, plus any wait while the
// output register is held by the consumer. A pixel beat after the last pixel
// of a frame and a flush beat before it are dropped. Writing either dimension
// restarts the frame; do so only while the block is idle.
module box_filter_3x3_edge_aware (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bfe_pkg::in_beat_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bfe_pkg::out_beat_t                out_data,
  input  logic                              cfg_we,
  input  bfe_pkg::cfg_idx_t                 cfg_index,
  input  logic [bfe_pkg::DIM_W-1:0]         cfg_wdata
);

  bfe_pkg::state_t state_r, state_nxt;

  logic [bfe_pkg::DIM_W-1:0] width_r, height_r;
  logic [bfe_pkg::DIM_W-1:0] w_eff, h_eff;

  logic [bfe_pkg::COL_W-1:0] in_col_r, in_col_nxt;
  logic [bfe_pkg::ROW_W-1:0] in_row_r, in_row_nxt;
  logic                      done_r, done_nxt;
  logic [bfe_pkg::COL_W-1:0] out_col_r, out_col_nxt;
  logic [bfe_pkg::ROW_W-1:0] out_row_r, out_row_nxt;

  logic accept, is_flush, drop, take, primed, col_last, row_last;
  logic ram_wr, out_load;

  logic [bfe_pkg::COL_W-1:0] col_r;
  logic [bfe_pkg::PIX_W-1:0] pix_r;
  logic                      primed_r;

  logic [bfe_pkg::PIX_W-1:0] upper_rd, middle_rd;
  logic [bfe_pkg::PIX_W-1:0] win_r [3][3];

  logic                      up, down, left, right;
  logic [bfe_pkg::SUM_W-1:0] sum;
  logic [1:0]                pre;
  bfe_pkg::div_t             div_kind;

  logic [bfe_pkg::SUM_W-1:0]  x_r;
  bfe_pkg::div_t              div_r;
  logic                       rend_r, fend_r;
  logic [bfe_pkg::PROD_W-1:0] prod_r;
  logic [bfe_pkg::PIX_W-1:0]  quot;

  logic                out_valid_r;
  bfe_pkg::out_beat_t  out_data_r;

  assign w_eff = bfe_pkg::clamp_dim(width_r, bfe_pkg::DIM_W'(bfe_pkg::MAX_WIDTH));
  assign h_eff = bfe_pkg::clamp_dim(height_r, bfe_pkg::DIM_W'(bfe_pkg::MAX_HEIGHT));

  assign accept   = in_valid && in_ready;
  assign is_flush = (in_data.opcode == bfe_pkg::OP_FLUSH);
  assign drop     = (is_flush != done_r);
  assign take     = accept && !drop;
  assign primed   = (in_row_r >= bfe_pkg::ROW_W'(2)) ||
                    ((in_row_r == bfe_pkg::ROW_W'(1)) && (in_col_r != '0));
  assign col_last = (bfe_pkg::DIM_W'(in_col_r) + bfe_pkg::DIM_W'(1)) >= w_eff;
  assign row_last = (bfe_pkg::DIM_W'(in_row_r) + bfe_pkg::DIM_W'(1)) >= h_eff;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfe_pkg::ST_IDLE: begin
        if (take) begin
          state_nxt = bfe_pkg::ST_READ;
        end
      end
      bfe_pkg::ST_READ: begin
        state_nxt = primed_r ? bfe_pkg::ST_SUM : bfe_pkg::ST_IDLE;
      end
      bfe_pkg::ST_SUM: begin
        state_nxt = bfe_pkg::ST_MUL;
      end
      bfe_pkg::ST_MUL: begin
        state_nxt = bfe_pkg::ST_OUT;
      end
      bfe_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = bfe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bfe_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ram_wr   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      bfe_pkg::ST_IDLE: in_ready = 1'b1;
      bfe_pkg::ST_READ: ram_wr   = 1'b1;
      bfe_pkg::ST_OUT:  out_load = !out_valid_r || out_ready;
      default: begin
      end
    endcase
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    done_nxt    = done_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    priority if (cfg_we || (out_load && fend_r)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      done_nxt    = 1'b0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (take) begin
      if (col_last) begin
        in_col_nxt = '0;
        if (!done_r) begin
          if (row_last) begin
            done_nxt   = 1'b1;
            in_row_nxt = (in_row_r != '0) ? bfe_pkg::ROW_W'(2) : bfe_pkg::ROW_W'(1);
          end else begin
            in_row_nxt = in_row_r + bfe_pkg::ROW_W'(1);
          end
        end else if (in_row_r < bfe_pkg::ROW_W'(2)) begin
          in_row_nxt = in_row_r + bfe_pkg::ROW_W'(1);
        end
      end else begin
        in_col_nxt = in_col_r + bfe_pkg::COL_W'(1);
      end
    end else if (out_load) begin
      if (rend_r) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + bfe_pkg::ROW_W'(1);
      end else begin
        out_col_nxt = out_col_r + bfe_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bfe_pkg::ST_IDLE;
      width_r   <= bfe_pkg::DIM_W'(1);
      height_r  <= bfe_pkg::DIM_W'(1);
      in_col_r  <= '0;
      in_row_r  <= '0;
      done_r    <= 1'b0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      state_r   <= state_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      done_r    <= done_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          bfe_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
          bfe_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      col_r    <= in_col_r;
      pix_r    <= is_flush ? '0 : in_data.pixel_in;
      primed_r <= primed;
    end
  end

  bfe_ram #(
    .WIDTH(bfe_pkg::PIX_W),
    .DEPTH(bfe_pkg::MAX_WIDTH)
  ) u_upper_ram (
    .clk  (clk),
    .we   (ram_wr),
    .waddr(col_r),
    .wdata(middle_rd),
    .re   (take),
    .raddr(in_col_r),
    .rdata(upper_rd)
  );

  bfe_ram #(
    .WIDTH(bfe_pkg::PIX_W),
    .DEPTH(bfe_pkg::MAX_WIDTH)
  ) u_middle_ram (
    .clk  (clk),
    .we   (ram_wr),
    .waddr(col_r),
    .wdata(pix_r),
    .re   (take),
    .raddr(in_col_r),
    .rdata(middle_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (ram_wr) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= upper_rd;
      win_r[1][2] <= middle_rd;
      win_r[2][2] <= pix_r;
    end
  end

  assign up    = (out_row_r != '0);
  assign down  = (bfe_pkg::DIM_W'(out_row_r) + bfe_pkg::DIM_W'(1)) < h_eff;
  assign left  = (out_col_r != '0);
  assign right = (bfe_pkg::DIM_W'(out_col_r) + bfe_pkg::DIM_W'(1)) < w_eff;

  always_comb begin
    sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r != 0 || up) && (r != 2 || down) && (c != 0 || left) && (c != 2 || right)) begin
          sum = sum + bfe_pkg::SUM_W'(win_r[r][c]);
        end
      end
    end
  end

  // A count of 2 or 4 is a shift, 3 and 6 share the reciprocal of 3.
  always_comb begin
    pre = {1'b0, up ^ down} + {1'b0, left ^ right};
    priority if (up && down && left && right) begin
      div_kind = bfe_pkg::DIV_NINTH;
    end else if ((up && down) || (left && right)) begin
      div_kind = bfe_pkg::DIV_THIRD;
    end else begin
      div_kind = bfe_pkg::DIV_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bfe_pkg::ST_SUM) begin
      x_r    <= sum >> pre;
      div_r  <= div_kind;
      rend_r <= !right;
      fend_r <= !right && !down;
    end
    if (state_r == bfe_pkg::ST_MUL) begin
      prod_r <= bfe_pkg::PROD_W'(x_r) * bfe_pkg::PROD_W'(bfe_pkg::div_mult(div_r));
    end
  end

  always_comb begin
    unique case (div_r)
      bfe_pkg::DIV_THIRD: quot = prod_r[bfe_pkg::THIRD_SHIFT +: bfe_pkg::PIX_W];
      bfe_pkg::DIV_NINTH: quot = prod_r[bfe_pkg::NINTH_SHIFT +: bfe_pkg::PIX_W];
      default:            quot = prod_r[bfe_pkg::PIX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.pixel_out <= quot;
      out_data_r.row_end   <= rend_r;
      out_data_r.frame_end <= fend_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/bfe_checker.sv
module bfe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bfe_pkg::out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 5))
    else $error("result beat without an input beat five cycles earlier");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.row_end)
    else $error("frame end flagged without row end");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("input side went busy without an accepted beat");

endmodule

bind box_filter_3x3_edge_aware bfe_checker u_bfe_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
